@@ rtl/crs_pkg.sv @@
// Shared types, constants and gain tables for the stereo comb reverb.
// Depends on nothing; imported by crs_len_div and comb_reverb_stereo_unit.
package crs_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int RATE_W     = 18;
    localparam int BASE_W     = 11;
    localparam int PROD_W     = BASE_W + RATE_W;
    localparam int PCT_W      = 7;
    localparam int FSB_W      = 5;
    localparam int GAIN_W     = 25;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int RATE_BASIS = 44100;

    localparam longint Q24_ONE = 64'sd1 << 24;
    localparam logic [GAIN_W-1:0] Q24_UNITY = 25'h100_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO      = 3'd6;

    localparam logic [BASE_W-1:0] TUNING [8] = '{
        11'd1116, 11'd1188, 11'd1277, 11'd1356,
        11'd1139, 11'd1211, 11'd1300, 11'd1379
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_beat;

    typedef logic [127:0][GAIN_W-1:0] t_gain_tab;

    function automatic t_gain_tab fb_tab_build();
        t_gain_tab tab;
        longint    r;
        for (int p = 0; p < 128; p++) begin
            r = (p > 100) ? 64'sd100 : longint'(p);
            tab[p] = GAIN_W'((Q24_ONE / 100) * (60 + (r * 35) / 100));
        end
        return tab;
    endfunction

    function automatic t_gain_tab d1_tab_build();
        t_gain_tab tab;
        longint    r;
        for (int p = 0; p < 128; p++) begin
            r = (p > 100) ? 64'sd100 : longint'(p);
            tab[p] = GAIN_W'((Q24_ONE * r * 9) / 1000);
        end
        return tab;
    endfunction

    function automatic t_gain_tab wg_tab_build();
        t_gain_tab tab;
        longint    r;
        for (int p = 0; p < 128; p++) begin
            r = (p > 100) ? 64'sd100 : longint'(p);
            tab[p] = GAIN_W'((r * Q24_ONE) / 100);
        end
        return tab;
    endfunction

    localparam t_gain_tab FB_TAB = fb_tab_build();
    localparam t_gain_tab D1_TAB = d1_tab_build();
    localparam t_gain_tab WG_TAB = wg_tab_build();

    // Base length of a line: first half uses the left set, the rest the right set.
    function automatic logic [BASE_W-1:0] line_base(input logic [3:0] idx,
                                                    input logic [3:0] cnt);
        logic [3:0] half;
        logic [3:0] off;
        half = cnt >> 1;
        off  = idx - half;
        if (idx < half) begin
            return TUNING[{1'b0, idx[1:0]}];
        end else begin
            return TUNING[{1'b1, off[1:0]}];
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

@@ rtl/crs_len_div.sv @@
// Comb line length unit: base * rate / 44100, clamped to 1..MAX_LINE_LENGTH.
// Product, reciprocal multiply and clamp, each a registered step. Uses crs_pkg.
module crs_len_div #(
    parameter int MAX_LINE_LENGTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [crs_pkg::BASE_W-1:0]             i_base,
    input  logic [crs_pkg::RATE_W-1:0]             i_rate,
    output logic                                   o_done,
    output logic [$clog2(MAX_LINE_LENGTH+1)-1:0]   o_len
);
    import crs_pkg::*;

    localparam int LW       = $clog2(MAX_LINE_LENGTH + 1);
    localparam int RECIP_SH = PROD_W + 16;
    localparam int RECIP_W  = RECIP_SH - 15;
    localparam int MP_W     = PROD_W + RECIP_W;
    localparam int QW       = MP_W - RECIP_SH;
    // ceil(2^RECIP_SH / 44100): exact quotient for any PROD_W-bit product
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'sd1 << RECIP_SH) + RATE_BASIS - 1) / RATE_BASIS);
    localparam logic [QW-1:0] QMAX = QW'(MAX_LINE_LENGTH);

    logic              r_mul_go;
    logic              r_clamp_go;
    logic              r_done;
    logic [PROD_W-1:0] r_prod;
    logic [QW-1:0]     r_q;
    logic [LW-1:0]     r_len;

    logic [MP_W-1:0]   recip_prod;

    assign recip_prod = MP_W'(r_prod) * MP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_go   <= 1'b0;
            r_clamp_go <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_mul_go   <= i_start;
            r_clamp_go <= r_mul_go;
            r_done     <= r_clamp_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_base) * PROD_W'(i_rate);
        end
        if (r_mul_go) begin
            r_q <= recip_prod[MP_W-1:RECIP_SH];
        end
        if (r_clamp_go) begin
            if (r_q == '0) begin
                r_len <= LW'(1);
            end else if (r_q >= QMAX) begin
                r_len <= LW'(MAX_LINE_LENGTH);
            end else begin
                r_len <= LW'(r_q);
            end
        end
    end

    assign o_done = r_done;
    assign o_len  = r_len;

endmodule

@@ rtl/comb_reverb_stereo_unit.sv @@
// Stereo comb reverb: each beat (L, R) drives eight damped comb lines, four per side, whose
// wet sums are scaled and added to the dry samples, then clamped to full scale. A reverb beat
// takes each line through read, damping products, feedback product and write, on one shared
// 33x26 multiplier, then scales each side's wet sum before handing the beat over. The first
// reverb beat after reset or after a sample_rate write also recomputes the line lengths, one
// line at a time in the length unit. A pass-through beat (disabled or zero mix) goes straight
// from accept to hand-over. After reset the delay memory is zeroed, one word a cycle, over
// 2^(clog2(LINE_COUNT)+clog2(MAX_LINE_LENGTH)) words (16384 at defaults); input stalls then.
// Depends on crs_pkg and crs_len_div.
module comb_reverb_stereo_unit #(
    parameter int MAX_LINE_LENGTH = 2048,
    parameter int LINE_COUNT      = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  crs_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output crs_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import crs_pkg::*;

    localparam int LB        = $clog2(LINE_COUNT);
    localparam int PB        = $clog2(MAX_LINE_LENGTH);
    localparam int LW        = $clog2(MAX_LINE_LENGTH + 1);
    localparam int AW        = LB + PB;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int HALF      = LINE_COUNT / 2;
    localparam int WW        = SAMPLE_W + $clog2(LINE_COUNT);
    localparam int ACC_W     = WW + MUL_B_W;
    localparam int SUM_W     = ACC_W - 23;
    localparam int DRV_W     = SAMPLE_W - 3;

    typedef enum logic [14:0] {
        S_CLR      = 15'b000_0000_0000_0001,
        S_IDLE     = 15'b000_0000_0000_0010,
        S_LEN_GO   = 15'b000_0000_0000_0100,
        S_LEN_WAIT = 15'b000_0000_0000_1000,
        S_RD       = 15'b000_0000_0001_0000,
        S_MA       = 15'b000_0000_0010_0000,
        S_MB       = 15'b000_0000_0100_0000,
        S_MC       = 15'b000_0000_1000_0000,
        S_MD       = 15'b000_0001_0000_0000,
        S_WR       = 15'b000_0010_0000_0000,
        S_WA       = 15'b000_0100_0000_0000,
        S_WB       = 15'b000_1000_0000_0000,
        S_WC       = 15'b001_0000_0000_0000,
        S_WD       = 15'b010_0000_0000_0000,
        S_PUT      = 15'b100_0000_0000_0000
    } t_state;

    // config
    logic              r_enabled;
    logic [PCT_W-1:0]  r_room;
    logic [PCT_W-1:0]  r_damp;
    logic [PCT_W-1:0]  r_mix;
    logic [RATE_W-1:0] r_rate;
    logic [FSB_W-1:0]  r_fsb;
    logic              r_stereo;

    // control
    t_state            r_state;
    logic [LB-1:0]     r_line;
    logic              r_side;
    logic              r_len_ok;
    logic [AW-1:0]     r_clr_addr;
    logic              r_out_valid;
    logic [PB-1:0]     r_pos [LINE_COUNT];
    logic signed [SAMPLE_W-1:0] r_lp [LINE_COUNT];

    // payload
    logic [LW-1:0]              r_len [LINE_COUNT];
    logic signed [SAMPLE_W-1:0] r_l;
    logic signed [SAMPLE_W-1:0] r_r;
    logic signed [DRV_W-1:0]    r_drive;
    logic [GAIN_W-1:0]          r_fb;
    logic [GAIN_W-1:0]          r_d1;
    logic [GAIN_W-1:0]          r_d2;
    logic [GAIN_W-1:0]          r_wg;
    logic signed [WW-1:0]       r_wet_l;
    logic signed [WW-1:0]       r_wet_r;
    logic signed [MUL_P_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_res_l;
    logic signed [SAMPLE_W-1:0] r_res_r;
    t_out_beat                  r_out;

    logic signed [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd;

    logic                        in_acc;
    logic                        active;
    logic                        put_ok;
    logic                        last_line;
    logic                        div_start;
    logic                        div_done;
    logic [LW-1:0]               div_len;
    logic [PB-1:0]               pos_cur;
    logic [PB:0]                 pos_inc;
    logic [AW-1:0]               mem_addr;
    logic                        mem_we;
    logic signed [SAMPLE_W-1:0]  mem_wdata;
    logic signed [SAMPLE_W-1:0]  filt;
    logic signed [SAMPLE_W:0]    in_sum;
    logic signed [SAMPLE_W-1:0]  right_sel;
    logic signed [WW-1:0]        wet_sel;
    logic signed [WW-17:0]       wet_hi;
    logic [15:0]                 wet_lo;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic [SAMPLE_W-1:0]         lim32;
    logic signed [SUM_W-1:0]     lim_s;
    logic signed [SUM_W-1:0]     wsum;
    logic signed [SUM_W-1:0]     wclamp;

    crs_len_div #(
        .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
    ) u_len_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_base  (line_base(4'(r_line), 4'(LINE_COUNT))),
        .i_rate  (r_rate),
        .o_done  (div_done),
        .o_len   (div_len)
    );

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign active    = r_enabled && (r_mix != '0);
    assign put_ok    = (r_state == S_PUT) && (!r_out_valid || !i_out_stall);
    assign last_line = (r_line == LB'(LINE_COUNT - 1));
    assign div_start = (r_state == S_LEN_GO);
    assign pos_cur   = r_pos[r_line];
    assign pos_inc   = {1'b0, pos_cur} + (PB+1)'(1);
    assign right_sel = r_stereo ? i_in_data.right_in : i_in_data.left_in;
    assign in_sum    = (SAMPLE_W+1)'(i_in_data.left_in) + (SAMPLE_W+1)'(right_sel);

    assign filt      = sat32(64'(r_acc >>> 24));
    assign mem_wdata = (r_state == S_CLR) ? '0 :
                       sat32(64'(r_drive) + 64'(r_prod >>> 24));
    assign mem_we    = (r_state == S_CLR) || (r_state == S_WR);
    assign mem_addr  = (r_state == S_CLR) ? r_clr_addr : {r_line, pos_cur};

    assign wet_sel = r_side ? r_wet_r : r_wet_l;
    assign wet_hi  = wet_sel[WW-1:16];
    assign wet_lo  = wet_sel[15:0];

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MA: begin
                mul_a = MUL_A_W'(r_rd);
                mul_b = {1'b0, r_d2};
            end
            S_MB: begin
                mul_a = MUL_A_W'(r_lp[r_line]);
                mul_b = {1'b0, r_d1};
            end
            S_MD: begin
                mul_a = MUL_A_W'(filt);
                mul_b = {1'b0, r_fb};
            end
            S_WA: begin
                mul_a = MUL_A_W'(wet_hi);
                mul_b = {1'b0, r_wg};
            end
            S_WB: begin
                mul_a = {{(MUL_A_W-16){1'b0}}, wet_lo};
                mul_b = {1'b0, r_wg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign lim32  = SAMPLE_W'((33'd1 << r_fsb) - 33'd1);
    assign lim_s  = SUM_W'({1'b0, lim32});
    assign wsum   = SUM_W'(r_side ? r_r : r_l) + SUM_W'(r_acc >>> 24);
    assign wclamp = (wsum > lim_s) ? lim_s : ((wsum < -lim_s) ? -lim_s : wsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_room    <= PCT_W'(50);
            r_damp    <= PCT_W'(50);
            r_mix     <= '0;
            r_rate    <= RATE_W'(RATE_BASIS);
            r_fsb     <= FSB_W'(27);
            r_stereo  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLED:     r_enabled <= i_cfg_data[0];
                REG_ROOM_SIZE:   r_room    <= i_cfg_data[PCT_W-1:0];
                REG_DAMPING:     r_damp    <= i_cfg_data[PCT_W-1:0];
                REG_WET_MIX:     r_mix     <= i_cfg_data[PCT_W-1:0];
                REG_SAMPLE_RATE: r_rate    <= i_cfg_data[RATE_W-1:0];
                REG_FULL_SCALE:  r_fsb     <= i_cfg_data[FSB_W-1:0];
                REG_STEREO:      r_stereo  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_line      <= '0;
            r_side      <= 1'b0;
            r_len_ok    <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LINE_COUNT; i++) begin
                r_pos[i] <= '0;
                r_lp[i]  <= '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_SAMPLE_RATE)) begin
                r_len_ok <= 1'b0;
            end
            if (put_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_line <= '0;
                        r_side <= 1'b0;
                        if (!active) begin
                            r_state <= S_PUT;
                        end else if (r_len_ok) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_LEN_GO;
                        end
                    end
                end
                S_LEN_GO: r_state <= S_LEN_WAIT;
                S_LEN_WAIT: begin
                    if (div_done) begin
                        if (LW'(pos_cur) >= div_len) begin
                            r_pos[r_line] <= '0;
                        end
                        if (last_line) begin
                            r_line   <= '0;
                            r_len_ok <= 1'b1;
                            r_state  <= S_RD;
                        end else begin
                            r_line  <= r_line + LB'(1);
                            r_state <= S_LEN_GO;
                        end
                    end
                end
                S_RD: r_state <= S_MA;
                S_MA: r_state <= S_MB;
                S_MB: r_state <= S_MC;
                S_MC: r_state <= S_MD;
                S_MD: begin
                    r_lp[r_line] <= filt;
                    r_state      <= S_WR;
                end
                S_WR: begin
                    if (pos_inc >= (PB+1)'(r_len[r_line])) begin
                        r_pos[r_line] <= '0;
                    end else begin
                        r_pos[r_line] <= pos_inc[PB-1:0];
                    end
                    if (last_line) begin
                        r_side  <= 1'b0;
                        r_state <= S_WA;
                    end else begin
                        r_line  <= r_line + LB'(1);
                        r_state <= S_RD;
                    end
                end
                S_WA: r_state <= S_WB;
                S_WB: r_state <= S_WC;
                S_WC: r_state <= S_WD;
                S_WD: begin
                    if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_WA;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_l     <= i_in_data.left_in;
                    r_r     <= right_sel;
                    r_drive <= in_sum[SAMPLE_W:4];
                    r_fb    <= FB_TAB[r_room];
                    r_d1    <= D1_TAB[r_damp];
                    r_d2    <= Q24_UNITY - D1_TAB[r_damp];
                    r_wg    <= WG_TAB[r_mix];
                    r_wet_l <= '0;
                    r_wet_r <= '0;
                    r_res_l <= i_in_data.left_in;
                    r_res_r <= r_stereo ? i_in_data.right_in : '0;
                end
            end
            S_LEN_WAIT: begin
                if (div_done) begin
                    r_len[r_line] <= div_len;
                end
            end
            S_MA: begin
                if (r_line < LB'(HALF)) begin
                    r_wet_l <= r_wet_l + WW'(r_rd);
                end else begin
                    r_wet_r <= r_wet_r + WW'(r_rd);
                end
            end
            S_MB: r_acc <= ACC_W'(r_prod);
            S_MC: r_acc <= r_acc + ACC_W'(r_prod);
            S_WB: r_acc <= ACC_W'(r_prod) <<< 16;
            S_WC: r_acc <= r_acc + ACC_W'(r_prod);
            S_WD: begin
                if (!r_side) begin
                    r_res_l <= wclamp[SAMPLE_W-1:0];
                end else begin
                    r_res_r <= r_stereo ? wclamp[SAMPLE_W-1:0] : '0;
                end
            end
            S_PUT: begin
                if (put_ok) begin
                    r_out.left_out  <= r_res_l;
                    r_out.right_out <= r_res_r;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_addr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < LINE_COUNT; g++) begin : g_pos_chk
        a_pos_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_len_ok |-> (LW'(r_pos[g]) < r_len[g]))
            else $error("line position beyond line length");
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((div_len != '0) && (div_len <= LW'(MAX_LINE_LENGTH))))
        else $error("line length out of range");

    a_out_from_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_PUT))
        else $error("output beat raised outside hand-over");

endmodule
